[rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and
// get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset.
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spq assertion failed");

// Check a property on every rising edge, reset cycles included.
`define SPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("spq assertion failed");

`else

`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Word types, opcodes, status codes and cell commands for the stable
// priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int PORT_TAG_W = 16;
  localparam int PRI_W      = 8;
  localparam int OCC_W      = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_EMPTY    = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;
  localparam logic [1:0] STS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [PORT_TAG_W-1:0] tag;
    logic [PRI_W-1:0]      priority_req;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PORT_TAG_W-1:0] out_tag;
    logic [PRI_W-1:0]      out_priority;
    logic [OCC_W-1:0]      occupancy;
  } out_word_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;   // open a slot and drop the new entry in
    logic pop;   // shift toward the head
    logic rot;   // rotate the occupied part by one place
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/stable_priority_queue_top.sv]
// Insert, remove and no-op words need no scan: the result word is registered
// at the accepting edge, and a new word can enter every cycle while no scan
// runs and the result slot is free or draining. A lookup on a non-empty queue
// rotates the chain once around its occupied part, checking the head each step.
// Synchronous active-low reset empties the queue and drops any held result.
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue held as a chain of cells in descending priority
// order; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stable_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int TAG_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Controller states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_left_r, scan_left_nxt;
  logic [TAG_WIDTH-1:0] scan_tag_r, scan_tag_nxt;
  logic                 found_r, found_nxt;
  logic [PRI_W-1:0]     found_pri_r, found_pri_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 in_acc;
  logic                 is_full;
  logic                 is_empty;
  logic                 hit;
  logic [TAG_WIDTH-1:0] in_tag_w;
  cell_cmd_t            cmd;

  logic [TAG_WIDTH-1:0] cell_tag   [DEPTH];
  logic [PRI_W-1:0]     cell_pri   [DEPTH];
  logic                 cell_ahead [DEPTH];
  logic [TAG_WIDTH-1:0] prev_tag   [DEPTH];
  logic [PRI_W-1:0]     prev_pri   [DEPTH];
  logic                 prev_ahead [DEPTH];
  logic [TAG_WIDTH-1:0] next_tag   [DEPTH];
  logic [PRI_W-1:0]     next_pri   [DEPTH];

  // Tags are stored and compared in their low TAG_WIDTH bits.
  assign in_tag_w = TAG_WIDTH'(in_word.tag);

  // Take a word only when idle and the result slot is free or draining.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign is_full  = count_r == CNT_W'(DEPTH);
  assign is_empty = count_r == '0;
  assign hit      = cell_tag[0] == scan_tag_r;

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 is the head. Each cell sees its two neighbors; the
  // head cell takes the new entry directly, the tail cell refills from itself.
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_tag[g]   = in_tag_w;
      assign prev_pri[g]   = in_word.priority_req;
      assign prev_ahead[g] = 1'b0;
    end else begin : g_inner
      assign prev_tag[g]   = cell_tag[g-1];
      assign prev_pri[g]   = cell_pri[g-1];
      assign prev_ahead[g] = cell_ahead[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign next_tag[g] = cell_tag[g];
      assign next_pri[g] = cell_pri[g];
    end else begin : g_body
      assign next_tag[g] = cell_tag[g+1];
      assign next_pri[g] = cell_pri[g+1];
    end

    spq_cell #(
      .IDX       (g),
      .TAG_WIDTH (TAG_WIDTH),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count_r),
      .new_tag    (in_tag_w),
      .new_pri    (in_word.priority_req),
      .prev_tag   (prev_tag[g]),
      .prev_pri   (prev_pri[g]),
      .prev_ahead (prev_ahead[g]),
      .next_tag   (next_tag[g]),
      .next_pri   (next_pri[g]),
      .head_tag   (cell_tag[0]),
      .head_pri   (cell_pri[0]),
      .tag        (cell_tag[g]),
      .pri        (cell_pri[g]),
      .ahead      (cell_ahead[g])
    );
  end

  // --------------------------------------------------------------------------
  // Control: decode the accepted word, drive the chain, build the result.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_left_nxt = scan_left_r;
    scan_tag_nxt  = scan_tag_r;
    found_nxt     = found_r;
    found_pri_nxt = found_pri_r;
    // Hold the result word until the consumer takes it.
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    cmd           = '0;

    if (state_r == S_IDLE) begin
      if (in_acc) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{status: STS_OK, out_tag: '0, out_priority: '0,
                          occupancy: OCC_W'(count_r)};
        case (in_word.opcode)
          OP_INSERT: begin
            if (is_full) begin
              // Drop the entry, report full.
              out_word_nxt.status = STS_FULL;
            end else begin
              cmd.ins                = 1'b1;
              count_nxt              = count_r + 1'b1;
              out_word_nxt.occupancy = OCC_W'(count_nxt);
            end
          end
          OP_REMOVE: begin
            if (is_empty) begin
              out_word_nxt.status = STS_EMPTY;
            end else begin
              cmd.pop                   = 1'b1;
              count_nxt                 = count_r - 1'b1;
              out_word_nxt.out_tag      = PORT_TAG_W'(cell_tag[0]);
              out_word_nxt.out_priority = cell_pri[0];
              out_word_nxt.occupancy    = OCC_W'(count_nxt);
            end
          end
          OP_LOOKUP: begin
            if (is_empty) begin
              out_word_nxt.status  = STS_EMPTY;
              out_word_nxt.out_tag = PORT_TAG_W'(in_tag_w);
            end else begin
              // Start a full rotation; the result comes at its end.
              out_valid_nxt = 1'b0;
              state_nxt     = S_SCAN;
              scan_left_nxt = count_r;
              scan_tag_nxt  = in_tag_w;
              found_nxt     = 1'b0;
              found_pri_nxt = '0;
            end
          end
          default: begin
            // Unused opcode: no operation, plain ok word.
          end
        endcase
      end
    end else begin
      // Advance the ring by one; the first match at the head wins.
      cmd.rot       = 1'b1;
      scan_left_nxt = scan_left_r - 1'b1;
      found_nxt     = found_r || hit;
      if (!found_r && hit) begin
        found_pri_nxt = cell_pri[0];
      end
      if (scan_left_r == CNT_W'(1)) begin
        // Order is restored after this step: post the result.
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_word_nxt  = '{status: found_nxt ? STS_OK : STS_NOTFOUND,
                          out_tag: PORT_TAG_W'(scan_tag_r),
                          out_priority: found_pri_nxt,
                          occupancy: OCC_W'(count_r)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_left_r <= scan_left_nxt;
    scan_tag_r  <= scan_tag_nxt;
    found_r     <= found_nxt;
    found_pri_r <= found_pri_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SPQ_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH))
  `SPQ_ASSERT(a_scan_blocks_input, (state_r == S_SCAN) |-> !in_ready)
  `SPQ_ASSERT(a_full_insert_keeps_count,
              (in_acc && in_word.opcode == OP_INSERT && is_full) |=> $stable(count_r))
  `SPQ_ASSERT(a_scan_end_posts_result,
              (state_r == S_SCAN && scan_left_r == CNT_W'(1)) |=>
              (out_valid_r && state_r == S_IDLE))
  `SPQ_ASSERT(a_scan_nonzero, (state_r == S_SCAN) |-> (scan_left_r != '0 && !out_valid_r))
  `SPQ_ASSERT_ALWAYS(a_reset_clears,
                     !rst_n |=> (count_r == '0 && state_r == S_IDLE && !out_valid_r))

endmodule

`default_nettype wire

[rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the shift-register queue: holds a tag and a priority and
// trades them with its neighbors on insert, pop and rotate.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX       = 0,
  parameter int TAG_WIDTH = 16,
  parameter int CNT_W     = 5
) (
  input  wire logic                 clk,
  input  wire cell_cmd_t            cmd,
  input  wire logic [CNT_W-1:0]     count,
  input  wire logic [TAG_WIDTH-1:0] new_tag,
  input  wire logic [PRI_W-1:0]     new_pri,
  input  wire logic [TAG_WIDTH-1:0] prev_tag,
  input  wire logic [PRI_W-1:0]     prev_pri,
  input  wire logic                 prev_ahead,
  input  wire logic [TAG_WIDTH-1:0] next_tag,
  input  wire logic [PRI_W-1:0]     next_pri,
  input  wire logic [TAG_WIDTH-1:0] head_tag,
  input  wire logic [PRI_W-1:0]     head_pri,
  output logic [TAG_WIDTH-1:0]      tag,
  output logic [PRI_W-1:0]          pri,
  output logic                      ahead
);

  logic [TAG_WIDTH-1:0] tag_r, tag_nxt;
  logic [PRI_W-1:0]     pri_r, pri_nxt;
  logic                 occ;
  logic                 last;

  assign occ    = CNT_W'(IDX) < count;
  assign last   = count == CNT_W'(IDX + 1);
  // New entry lands ahead of this slot when the slot is free or weaker.
  assign ahead  = !occ || (pri_r < new_pri);

  always_comb begin
    tag_nxt = tag_r;
    pri_nxt = pri_r;
    if (cmd.ins && ahead) begin
      if (prev_ahead) begin
        tag_nxt = prev_tag;
        pri_nxt = prev_pri;
      end else begin
        tag_nxt = new_tag;
        pri_nxt = new_pri;
      end
    end else if (cmd.pop) begin
      tag_nxt = next_tag;
      pri_nxt = next_pri;
    end else if (cmd.rot) begin
      if (last) begin
        tag_nxt = head_tag;
        pri_nxt = head_pri;
      end else begin
        tag_nxt = next_tag;
        pri_nxt = next_pri;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
    pri_r <= pri_nxt;
  end

  assign tag = tag_r;
  assign pri = pri_r;

endmodule

`default_nettype wire
